// ===== src/jsu_pkg.sv =====
package jsu_pkg;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_U         = 8'h75;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;

	localparam int unsigned MAX_OUT = 5;
	localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);
	localparam int unsigned HELD_N  = 3;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_HEX   = 2'd2
	} mode_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_value(input logic [7:0] c);
		hex_digit_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== src/json_string_unescape.sv =====
// channel   dir  tdata         tlast     notes
// s_axis    in   [7:0] in_byte in_last   one raw string character per transfer
// m_axis    out  [7:0] out_byte out_last one unescaped byte per transfer
//
// one input transfer per cycle; each item is decoded in the cycle it is taken
// and its zero to five output bytes sit in a result register that drains one
// byte per cycle, so a burst of several bytes holds off input until it drains
// a new item is taken in the cycle the last byte of the previous group leaves
// reset returns to plain text with no pending output
// output stalls hold the result register and lower s_tready
module json_string_unescape
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // out_last
);

	mode_t            mode_q, mode_d;
	logic [1:0]       hex_q, hex_d;
	logic [7:0]       held_q [HELD_N];

	logic [7:0]       grp_q [MAX_OUT];
	logic [CNT_W-1:0] cnt_q;
	logic             grp_last_q;

	logic [7:0]       nb [MAX_OUT];
	logic [CNT_W-1:0] n;
	logic             held_we;

	logic             s_xfer, m_xfer;
	logic [7:0]       c;
	logic             last;

	hex_digit_t       h0, h1, h2, h3;
	logic [15:0]      code;

	assign c      = s_tdata;
	assign last   = s_tlast;
	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;

	assign m_tvalid = (cnt_q != '0);
	assign s_tready = (cnt_q == '0) || (m_tready && cnt_q == CNT_W'(1));
	assign m_tdata  = grp_q[0];
	assign m_tlast  = grp_last_q && (cnt_q == CNT_W'(1));

	assign h0   = hex_value(held_q[0]);
	assign h1   = hex_value(held_q[1]);
	assign h2   = hex_value(held_q[2]);
	assign h3   = hex_value(c);
	assign code = {h0.val, h1.val, h2.val, h3.val};

	// next state
	always_comb begin
		mode_d  = MODE_PLAIN;
		hex_d   = hex_q;
		held_we = 1'b0;
		unique case (mode_q)
			MODE_ESC: begin
				if (c == CH_U && !last) begin
					mode_d = MODE_HEX;
					hex_d  = 2'd0;
				end
			end
			MODE_HEX: begin
				if (hex_q != 2'd3) begin
					held_we = 1'b1;
					if (!last) begin
						mode_d = MODE_HEX;
						hex_d  = hex_q + 2'd1;
					end
				end
			end
			default: begin
				if (c == CH_BACKSLASH && !last) begin
					mode_d = MODE_ESC;
				end
			end
		endcase
		if (last || mode_d != MODE_HEX) begin
			hex_d = (mode_d == MODE_HEX) ? hex_d : 2'd0;
		end
	end

	// output group
	always_comb begin
		for (int i = 0; i < MAX_OUT; i++) begin
			nb[i] = c;
		end
		n = '0;
		unique case (mode_q)
			MODE_ESC: begin
				unique case (c)
					CH_N: begin
						n = CNT_W'(1); nb[0] = CH_LF;
					end
					CH_T: begin
						n = CNT_W'(1); nb[0] = CH_TAB;
					end
					CH_R: begin
						n = CNT_W'(1); nb[0] = CH_CR;
					end
					CH_QUOTE, CH_BACKSLASH: begin
						n = CNT_W'(1);
					end
					CH_U: begin
						if (last) begin
							n = CNT_W'(2); nb[0] = CH_BACKSLASH; nb[1] = CH_U;
						end
					end
					default: begin
						n = CNT_W'(2); nb[0] = CH_BACKSLASH;
					end
				endcase
			end
			MODE_HEX: begin
				if (hex_q != 2'd3) begin
					if (last) begin
						n     = CNT_W'(hex_q) + CNT_W'(3);
						nb[0] = CH_BACKSLASH;
						nb[1] = CH_U;
						nb[2] = (hex_q != 2'd0) ? held_q[0] : c;
						nb[3] = (hex_q == 2'd2) ? held_q[1] : c;
					end
				end else if (!(h0.ok && h1.ok && h2.ok && h3.ok)) begin
					// malformed digit: low byte of the code, with bad digits taken as all ones
					n     = CNT_W'(1);
					nb[0] = (h2.ok ? {h2.val, 4'h0} : 8'hF0) | (h3.ok ? {4'h0, h3.val} : 8'hFF);
				end else if (code < 16'd128) begin
					n     = CNT_W'(1);
					nb[0] = code[7:0];
				end else if (code <= 16'h07FF) begin
					n     = CNT_W'(2);
					nb[0] = 8'hC0 | {3'b000, code[10:6]};
					nb[1] = 8'h80 | {2'b00, code[5:0]};
				end else begin
					n     = CNT_W'(3);
					nb[0] = 8'hE0 | {4'h0, code[15:12]};
					nb[1] = 8'h80 | {2'b00, code[11:6]};
					nb[2] = 8'h80 | {2'b00, code[5:0]};
				end
			end
			default: begin
				if (!(c == CH_BACKSLASH && !last)) begin
					n = CNT_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_PLAIN;
			hex_q      <= 2'd0;
			cnt_q      <= '0;
			grp_last_q <= 1'b0;
		end else begin
			if (s_xfer) begin
				mode_q     <= mode_d;
				hex_q      <= hex_d;
				cnt_q      <= n;
				grp_last_q <= last;
			end else if (m_xfer) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer && held_we) begin
			held_q[hex_q] <= c;
		end
		if (s_xfer) begin
			for (int i = 0; i < MAX_OUT; i++) begin
				grp_q[i] <= nb[i];
			end
		end else if (m_xfer) begin
			for (int i = 0; i < MAX_OUT - 1; i++) begin
				grp_q[i] <= grp_q[i+1];
			end
		end
	end

endmodule

// ===== src/jsu_checker.sv =====
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// stalled output holds
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// input is only held off while a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("s_tready low with no pending output");

	// the last character of a string always produces output
	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> m_tvalid)
		else $error("no output after last input transfer");

	// once the marked final byte leaves with no new input, no output is pending
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && !(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("output pending after final byte with no new input");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== bench/tb_json_string_unescape.sv =====
module tb_json_string_unescape;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;

	class unescape_scoreboard;
		beat_t       expected_q[$];
		mode_t       mode;
		int unsigned digits;
		logic [7:0]  held[3];
		int unsigned mismatches;

		function new();
			mode = MODE_PLAIN;
			digits = 0;
			mismatches = 0;
		endfunction

		function void push(logic [7:0] d, logic l);
			expected_q.push_back('{d, l});
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
			v = 4'h0;
			if (c >= 8'h30 && c <= 8'h39) begin
				v = 4'(c - 8'h30);
			end else if (c >= 8'h61 && c <= 8'h66) begin
				v = 4'(c - 8'h57);
			end else if (c >= 8'h41 && c <= 8'h46) begin
				v = 4'(c - 8'h37);
			end else begin
				return 1'b0;
			end
			return 1'b1;
		endfunction

		// predicts the output bytes caused by one accepted input transfer
		function void note_input(logic [7:0] c, logic l);
			logic [3:0]  d0, d1, d2, d3;
			bit          v0, v1, v2, v3;
			logic [15:0] code;
			case (mode)
			MODE_ESC: begin
				mode = MODE_PLAIN;
				case (c)
				CH_N:         push(CH_LF, l);
				CH_T:         push(CH_TAB, l);
				CH_R:         push(CH_CR, l);
				CH_QUOTE:     push(CH_QUOTE, l);
				CH_BACKSLASH: push(CH_BACKSLASH, l);
				CH_U: begin
					if (l) begin
						push(CH_BACKSLASH, 1'b0);
						push(CH_U, 1'b1);
					end else begin
						mode = MODE_HEX;
						digits = 0;
					end
				end
				default: begin
					push(CH_BACKSLASH, 1'b0);
					push(c, l);
				end
				endcase
			end
			MODE_HEX: begin
				if (digits < 3) begin
					held[digits] = c;
					if (l) begin
						// escape cut short: everything goes out raw
						push(CH_BACKSLASH, 1'b0);
						push(CH_U, 1'b0);
						for (int i = 0; i < digits; i++) begin
							push(held[i], 1'b0);
						end
						push(c, 1'b1);
						mode = MODE_PLAIN;
						digits = 0;
					end else begin
						digits++;
					end
				end else begin
					v0 = hex_nibble(held[0], d0);
					v1 = hex_nibble(held[1], d1);
					v2 = hex_nibble(held[2], d2);
					v3 = hex_nibble(c, d3);
					if (!(v0 && v1 && v2 && v3)) begin
						// bad digit acts as all ones, only the low byte survives
						push(v3 ? {(v2 ? d2 : 4'hF), d3} : 8'hFF, l);
					end else begin
						code = {d0, d1, d2, d3};
						if (code < 16'd128) begin
							push(code[7:0], l);
						end else if (code <= 16'h07FF) begin
							push(8'hC0 | {3'b000, code[10:6]}, 1'b0);
							push(8'h80 | {2'b00, code[5:0]}, l);
						end else begin
							push(8'hE0 | {4'h0, code[15:12]}, 1'b0);
							push(8'h80 | {2'b00, code[11:6]}, 1'b0);
							push(8'h80 | {2'b00, code[5:0]}, l);
						end
					end
					mode = MODE_PLAIN;
					digits = 0;
				end
			end
			default: begin
				if (c == CH_BACKSLASH && !l) begin
					mode = MODE_ESC;
				end else begin
					push(c, l);
				end
			end
			endcase
			if (l) begin
				mode = MODE_PLAIN;
				digits = 0;
			end
		endfunction

		function void check_output(logic [7:0] d, logic l);
			beat_t e;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected output transfer: out_byte %02h out_last %b", d, l));
				return;
			end
			e = expected_q.pop_front();
			if (d !== e.data) begin
				flag($sformatf("out_byte mismatch: expected %02h, got %02h", e.data, d));
			end
			if (l !== e.last) begin
				flag($sformatf("out_last mismatch: expected %b, got %b (out_byte %02h)",
					e.last, l, e.data));
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	unescape_scoreboard sb;
	beat_t text_q[$];
	int    items_sent = 0;
	int    burst_left = 0;
	bit    no_gaps = 1'b0;
	bit    hold_req = 1'b0;
	int    hold_left = 0;
	int    pattern_left = 0;
	int    ready_pct = 100;
	int    cycle_count = 0;

	json_string_unescape uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// transfers seen at this edge, noted before any output is checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_input(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				sb.check_output(m_tdata, m_tlast);
			end
		end
	end

	// receiver: random ready level, redrawn whenever a pattern runs out, plus long holds
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (pattern_left == 0) begin
			pattern_left = $urandom_range(16, 96);
			case ($urandom_range(0, 3))
			0: ready_pct = 100;
			1: ready_pct = 70;
			2: ready_pct = 35;
			default: ready_pct = 10;
			endcase
		end
		pattern_left--;
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if ($urandom_range(0, 3) == 0) begin
				gap = 0;
			end
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_tdata <= b;
		s_tlast <= l;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	function automatic void add_char(logic [7:0] b, logic l = 1'b0);
		text_q.push_back('{b, l});
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i]);
		end
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + n;
		end
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		logic [3:0] nib;
		bit         ok;
		do begin
			c = 8'($urandom_range(0, 255));
			ok = sb.hex_nibble(c, nib);
		end while (ok);
		return c;
	endfunction

	// sends the queued string with the end mark on its final character
	task automatic send_text();
		text_q[text_q.size() - 1].last = 1'b1;
		foreach (text_q[i]) begin
			send_item(text_q[i].data, text_q[i].last);
		end
		text_q.delete();
	endtask

	function automatic void build_string();
		int          segs;
		int          pos;
		logic [7:0]  b;
		logic [15:0] code;
		logic [7:0]  simple[5];
		simple = '{CH_N, CH_T, CH_R, CH_QUOTE, CH_BACKSLASH};
		if ($urandom_range(0, 9) == 0) begin
			// noise: escape-heavy random bytes with stray end marks
			segs = $urandom_range(1, 10);
			for (int k = 0; k < segs; k++) begin
				case ($urandom_range(0, 3))
				0: b = CH_BACKSLASH;
				1: b = CH_U;
				default: b = 8'($urandom_range(0, 255));
				endcase
				add_char(b, $urandom_range(0, 7) == 0);
			end
			return;
		end
		segs = $urandom_range(1, 6);
		for (int k = 0; k < segs; k++) begin
			case ($urandom_range(0, 9))
			0, 1, 2: begin
				b = 8'($urandom_range(0, 255));
				add_char(b == CH_BACKSLASH ? 8'h00 : b);
			end
			3: begin
				add_char(CH_BACKSLASH);
				add_char(simple[$urandom_range(0, 4)]);
			end
			4: begin
				do b = 8'($urandom_range(0, 255));
				while (b inside {CH_N, CH_T, CH_R, CH_QUOTE, CH_BACKSLASH, CH_U});
				add_char(CH_BACKSLASH);
				add_char(b);
			end
			5, 6, 7: begin
				case ($urandom_range(0, 2))
				0: code = 16'($urandom_range(0, 16'h007F));
				1: code = 16'($urandom_range(16'h0080, 16'h07FF));
				default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
				endcase
				add_char(CH_BACKSLASH);
				add_char(CH_U);
				for (int j = 3; j >= 0; j--) begin
					add_char(hex_char(code[j*4 +: 4]));
				end
			end
			default: begin
				pos = $urandom_range(0, 3);
				add_char(CH_BACKSLASH);
				add_char(CH_U);
				for (int j = 0; j < 4; j++) begin
					add_char(j == pos ? bad_char() : hex_char(4'($urandom_range(0, 15))));
				end
			end
			endcase
		end
		// sometimes the string ends inside an escape
		case ($urandom_range(0, 5))
		0: add_char(CH_BACKSLASH);
		1: begin
			add_char(CH_BACKSLASH);
			add_char(CH_U);
			pos = $urandom_range(0, 3);
			for (int j = 0; j < pos; j++) begin
				add_char($urandom_range(0, 1) ? hex_char(4'($urandom_range(0, 15)))
					: bad_char());
			end
		end
		default: ;
		endcase
	endfunction

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_char(8'h00);
		add_char(8'hFF);
		send_text();
		add_str("\\n\\t\\r\\\"\\\\\\q");
		send_text();
		add_str("\\u07fF\\uFFFF");
		send_text();
		add_str("\\u12g4");
		send_text();
		add_char(CH_BACKSLASH);
		send_text();
		add_str("\\u1");
		send_text();
		wait_drained();

		while (items_sent < 150) begin
			build_string();
			send_text();
		end

		// sender stops until everything is out, then runs flat out into a long output stall
		wait_drained();
		hold_req = 1'b1;
		no_gaps = 1'b1;
		while (items_sent < 200) begin
			build_string();
			send_text();
		end
		no_gaps = 1'b0;

		while (items_sent < 340) begin
			build_string();
			send_text();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/jsu_pkg.sv
src/json_string_unescape.sv
src/jsu_checker.sv
bench/tb_json_string_unescape.sv
